// File: rtl/core/cct_pkg.sv
// shared types, constants and the latin-1 fold function of the collation compare block
`default_nettype none

package cct_pkg;

  localparam int CODE_W          = 21;
  localparam int OP_W            = 3;
  localparam int VERDICT_W       = 2;
  localparam int EPOCH_W         = 6;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [OP_W-1:0] {
    OP_DISABLE  = 3'd0,
    OP_IDENTITY = 3'd1,
    OP_PRESET   = 3'd2,
    OP_WRITE    = 3'd3,
    OP_COMPARE  = 3'd4
  } op_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_LESS     = 2'd1,
    VERDICT_GREATER  = 2'd2,
    VERDICT_END      = 2'd3
  } verdict_t;

  typedef struct packed {
    logic              is_cmp;
    logic              err;
    logic [CODE_W-1:0] wa;
    logic [CODE_W-1:0] wb;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
  } q_entry_t;

  localparam logic [CODE_W-1:0] CH_UPPER_A = CODE_W'(65);
  localparam logic [CODE_W-1:0] CH_UPPER_C = CODE_W'(67);
  localparam logic [CODE_W-1:0] CH_UPPER_E = CODE_W'(69);
  localparam logic [CODE_W-1:0] CH_UPPER_I = CODE_W'(73);
  localparam logic [CODE_W-1:0] CH_UPPER_N = CODE_W'(78);
  localparam logic [CODE_W-1:0] CH_UPPER_O = CODE_W'(79);
  localparam logic [CODE_W-1:0] CH_UPPER_U = CODE_W'(85);
  localparam logic [CODE_W-1:0] CH_UPPER_Y = CODE_W'(89);
  localparam logic [CODE_W-1:0] CH_LOWER_Y = CODE_W'(121);
  localparam logic [CODE_W-1:0] CASE_DELTA = CODE_W'(32);
  localparam logic [CODE_W-1:0] LOWER_LO   = CODE_W'(224);
  localparam logic [CODE_W-1:0] LOWER_HI   = CODE_W'(253);
  localparam logic [CODE_W-1:0] Y_DIAER    = CODE_W'(255);

  function automatic logic [CODE_W-1:0] fold_of(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] up;
    logic [CODE_W-1:0] add;
    logic [CODE_W-1:0] res;
    up  = code;
    add = '0;
    if (code >= LOWER_LO && code <= LOWER_HI) begin
      up  = code - CASE_DELTA;
      add = CASE_DELTA;
    end
    if (up >= CODE_W'(192) && up <= CODE_W'(198)) res = CH_UPPER_A + add;
    else if (up == CODE_W'(199)) res = CH_UPPER_C + add;
    else if (up >= CODE_W'(200) && up <= CODE_W'(203)) res = CH_UPPER_E + add;
    else if (up >= CODE_W'(204) && up <= CODE_W'(207)) res = CH_UPPER_I + add;
    else if (up == CODE_W'(209)) res = CH_UPPER_N + add;
    else if (up >= CODE_W'(210) && up <= CODE_W'(214)) res = CH_UPPER_O + add;
    else if (up >= CODE_W'(217) && up <= CODE_W'(220)) res = CH_UPPER_U + add;
    else if (up == CODE_W'(221)) res = CH_UPPER_Y + add;
    else res = code;
    if (code == Y_DIAER) res = CH_LOWER_Y;
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cct_req_if.sv
// request channel: operation and character pair
`default_nettype none

interface cct_req_if import cct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CODE_W-1:0] code_a;
  logic [CODE_W-1:0] code_b;

  modport source(output valid, output operation, output code_a, output code_b, input ready);
  modport sink(input valid, input operation, input code_a, input code_b, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cct_rsp_if.sv
// result channel: verdict and range error
`default_nettype none

interface cct_rsp_if import cct_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 range_error;

  modport source(output valid, output verdict, output range_error, input ready);
  modport sink(input valid, input verdict, input range_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cct_ram.sv
// generic ram, one write port, two registered read ports
`default_nettype none

module cct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: rtl/core/cct_front.sv
// front end: accepts requests, keeps table state and weight memory, resolves weights
`default_nettype none

module cct_front import cct_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  cct_req_if.sink                                 cmd,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_count,
  output logic                                    push,
  output q_entry_t                                push_entry
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int BASE_W  = CODE_W - IDX_W;
  localparam int ENTRY_W = EPOCH_W + CODE_W;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } front_state_t;

  front_state_t        state;
  logic [IDX_W-1:0]    sweep_addr;
  logic                table_on;
  logic                preset_fold;
  logic [BASE_W-1:0]   window_base;
  logic [EPOCH_W-1:0]  epoch;
  logic                pend_valid;
  logic [IDX_W-1:0]    pend_idx;
  logic [CODE_W-1:0]   pend_weight;

  logic                s1_valid;
  logic                s1_cmp;
  logic                s1_err;
  logic                s1_on;
  logic                s1_fold;
  logic                s1_ina;
  logic                s1_inb;
  logic [EPOCH_W-1:0]  s1_epoch;
  logic [CODE_W-1:0]   s1_a;
  logic [CODE_W-1:0]   s1_b;

  logic                accept;
  logic [BASE_W-1:0]   a_base;
  logic [BASE_W-1:0]   b_base;
  logic [IDX_W-1:0]    a_idx;
  logic [IDX_W-1:0]    b_idx;
  logic                is_disable;
  logic                is_identity;
  logic                is_preset;
  logic                is_write;
  logic                is_cmp;
  logic                opens;
  logic                wrap;
  logic [BASE_W-1:0]   open_base;
  logic [EPOCH_W-1:0]  epoch_new;
  logic [BASE_W-1:0]   cur_base;
  logic [EPOCH_W-1:0]  cur_epoch;
  logic                wr_hit;
  logic                wr_err;
  logic [CNT_W:0]      fill;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  rd_a;
  logic [ENTRY_W-1:0]  rd_b;
  logic                hit_a;
  logic                hit_b;

  assign a_base = cmd.code_a[CODE_W-1:IDX_W];
  assign b_base = cmd.code_b[CODE_W-1:IDX_W];
  assign a_idx  = cmd.code_a[IDX_W-1:0];
  assign b_idx  = cmd.code_b[IDX_W-1:0];

  assign fill      = {1'b0, queue_count} + {{CNT_W{1'b0}}, s1_valid};
  assign cmd.ready = (state == ST_RUN) && (fill < (CNT_W+1)'(QUEUE_DEPTH));
  assign accept    = cmd.valid && cmd.ready;

  assign is_disable  = cmd.operation == OP_DISABLE;
  assign is_identity = cmd.operation == OP_IDENTITY;
  assign is_preset   = cmd.operation == OP_PRESET;
  assign is_write    = cmd.operation == OP_WRITE;
  assign is_cmp      = cmd.operation == OP_COMPARE;

  assign opens     = accept && (is_identity || is_preset || (is_write && !table_on));
  assign wrap      = opens && (epoch == EPOCH_LAST);
  assign open_base = is_preset ? '0 : a_base;
  assign epoch_new = (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_W'(1);
  assign cur_base  = opens ? open_base : window_base;
  assign cur_epoch = opens ? epoch_new : epoch;
  assign wr_hit    = accept && is_write && (a_base == cur_base);
  assign wr_err    = accept && is_write && (a_base != cur_base);

  // clearing pass marks every entry stale, except a write deferred by an epoch wrap
  always_comb begin
    if (state == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      if (pend_valid && (pend_idx == sweep_addr)) begin
        ram_wdata = {EPOCH_FIRST, pend_weight};
      end else begin
        ram_wdata = '0;
      end
    end else begin
      ram_we    = wr_hit;
      ram_waddr = a_idx;
      ram_wdata = {cur_epoch, cmd.code_b};
    end
  end

  cct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (a_idx),
    .raddr_b (b_idx),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      table_on    <= 1'b0;
      preset_fold <= 1'b0;
      window_base <= '0;
      epoch       <= EPOCH_FIRST;
      pend_valid  <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      s1_valid <= accept;
      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + IDX_W'(1);
          if (sweep_addr == '1) begin
            state      <= ST_RUN;
            pend_valid <= 1'b0;
          end
        end
        ST_RUN: begin
          if (wrap) begin
            state      <= ST_SWEEP;
            sweep_addr <= '0;
            pend_valid <= wr_hit;
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
      if (accept && is_disable) begin
        table_on <= 1'b0;
      end
      if (opens) begin
        table_on    <= 1'b1;
        preset_fold <= is_preset;
        window_base <= open_base;
        epoch       <= epoch_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wrap) begin
      pend_idx    <= a_idx;
      pend_weight <= cmd.code_b;
    end
    if (accept) begin
      s1_cmp   <= is_cmp;
      s1_err   <= wr_err;
      s1_on    <= table_on;
      s1_fold  <= preset_fold;
      s1_ina   <= a_base == window_base;
      s1_inb   <= b_base == window_base;
      s1_epoch <= epoch;
      s1_a     <= cmd.code_a;
      s1_b     <= cmd.code_b;
    end
  end

  assign hit_a = rd_a[ENTRY_W-1:CODE_W] == s1_epoch;
  assign hit_b = rd_b[ENTRY_W-1:CODE_W] == s1_epoch;

  always_comb begin
    push_entry.is_cmp = s1_cmp;
    push_entry.err    = s1_err;
    push_entry.a      = s1_a;
    push_entry.b      = s1_b;
    if (!s1_on || !s1_ina) push_entry.wa = s1_a;
    else if (hit_a)        push_entry.wa = rd_a[CODE_W-1:0];
    else if (s1_fold)      push_entry.wa = fold_of(s1_a);
    else                   push_entry.wa = s1_a;
    if (!s1_on || !s1_inb) push_entry.wb = s1_b;
    else if (hit_b)        push_entry.wb = rd_b[CODE_W-1:0];
    else if (s1_fold)      push_entry.wb = fold_of(s1_b);
    else                   push_entry.wb = s1_b;
  end

  assign push = s1_valid;

endmodule

`default_nettype wire

// File: rtl/core/cct_queue.sv
// short fifo between front and back
`default_nettype none

module cct_queue import cct_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire q_entry_t                     push_entry,
  input  wire logic                         pop,
  output logic                              head_valid,
  output q_entry_t                          head,
  output logic [$clog2(DEPTH+1)-1:0]        count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cct_back.sv
// back end: weight and code compare, result register
`default_nettype none

module cct_back import cct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire q_entry_t  head,
  output logic           pop,
  cct_rsp_if.source      res
);

  verdict_t verdict_next;

  always_comb begin
    if (!head.is_cmp)           verdict_next = VERDICT_CONTINUE;
    else if (head.wa < head.wb) verdict_next = VERDICT_LESS;
    else if (head.wa > head.wb) verdict_next = VERDICT_GREATER;
    else if (head.a < head.b)   verdict_next = VERDICT_LESS;
    else if (head.a > head.b)   verdict_next = VERDICT_GREATER;
    else if (head.a == '0)      verdict_next = VERDICT_END;
    else                        verdict_next = VERDICT_CONTINUE;
  end

  assign pop = head_valid && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (!res.valid || res.ready) begin
      res.valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.verdict     <= verdict_next;
      res.range_error <= head.err;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/collation_table_char_compare.sv
// top level of the collation weight table and character pair compare
`default_nettype none

// Takes one request per cycle while ready is high and returns exactly one result
// per request, in order. The front end owns the weight memory (one write and two
// read ports) and the table state; a compare reads both characters' weights in the
// cycle it is taken, and its result then passes the s1 register, the queue and the
// output register. A QUEUE_DEPTH-entry queue (four by default) and the output
// register let the result side stall on its own. After reset the front end clears
// every entry of the weight memory before it takes the first request. Table
// openings (identity reset, preset load, write while disabled) are tagged with a
// 6-bit generation; every 63rd opening wraps the tag and costs another clearing
// pass with requests held off. TABLE_DEPTH must be a power of two.
module collation_table_char_compare import cct_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  cct_req_if.sink    cmd,
  cct_rsp_if.source  res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic              push;
  q_entry_t          push_entry;
  logic              pop;
  logic              head_valid;
  q_entry_t          head;
  logic [CNT_W-1:0]  queue_count;

  cct_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .queue_count (queue_count),
    .push        (push),
    .push_entry  (push_entry)
  );

  cct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (queue_count)
  );

  cct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

endmodule

`default_nettype wire
